>>> sv/fec_block_window_tracker_top_assert.svh
// Assertion macros for the block window tracker checker
`ifndef FEC_BLOCK_WINDOW_TRACKER_TOP_ASSERT_SVH
`define FEC_BLOCK_WINDOW_TRACKER_TOP_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define FBWT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("check failed");
// next-cycle implication
`define FBWT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("check failed");
`endif

>>> sv/fbwt_pkg.sv
// Package: widths, action codes and helpers for the block window tracker
`timescale 1ns / 1ps
`default_nettype none
package fbwt_pkg;
	localparam int MaxMedia  = 32;
	localparam int MaxRepair = 16;
	localparam int SlotW     = $clog2(MaxMedia);
	localparam int RepW      = $clog2(MaxRepair);
	localparam int HeldW     = $clog2(MaxMedia + 1);
	localparam int RcntW     = $clog2(MaxRepair + 1);

	typedef enum logic [2:0] {
		ACT_STORED    = 3'd0,
		ACT_DUPLICATE = 3'd1,
		ACT_BLACKLIST = 3'd2,
		ACT_WINRESET  = 3'd3,
		ACT_COMPLETE  = 3'd4,
		ACT_RECOVER   = 3'd5,
		ACT_REPFULL   = 3'd6,
		ACT_IGNORED   = 3'd7
	} action_t;

	typedef struct packed {
		logic        opcode;
		logic [15:0] seq_number;
		logic [15:0] block_base;
		logic [15:0] packet_size;
	} in_word_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] present_mask;
		logic [15:0] largest_size_out;
		logic [15:0] base_out;
		logic [4:0]  repair_held;
	} out_word_t;

	// control from sequencer to the media cell row
	typedef struct packed {
		logic        shift;    // rotate ring one place toward head
		logic        keep;     // during rotate: reinsert head at tail
		logic        load;     // write new word at tail
		logic        clear;    // drop all
		logic [15:0] seq;
		logic [15:0] size;
	} row_ctl_t;

	function automatic logic [HeldW-1:0] eff_count(input logic [5:0] mc);
		logic [HeldW-1:0] m;
		begin
			if (mc == 6'd0) m = HeldW'(1);
			else if (int'(mc) > MaxMedia) m = HeldW'(MaxMedia);
			else m = HeldW'(mc);
			return m;
		end
	endfunction

	// unwrapped distance of seq from base in 17 bits
	function automatic logic [16:0] seq_dist(input logic [15:0] seq, input logic [15:0] base,
		input logic [HeldW-1:0] m);
		logic [16:0] v;
		begin
			v = {1'b0, seq};
			if (({1'b0, base} + 17'(m) > 17'h10000) && (seq < base)) v = v + 17'h10000;
			return v - {1'b0, base};
		end
	endfunction
endpackage
`default_nettype wire

>>> sv/fbwt_if.sv
// Valid/ready channel interface carrying one word
`timescale 1ns / 1ps
`default_nettype none
interface fbwt_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/fbwt_cell.sv
// One media store cell: holds a sequence number and size, shifts toward head
`timescale 1ns / 1ps
`default_nettype none
module fbwt_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 shift,
	input  wire logic                 clear,
	input  wire logic                 load_here,
	input  wire logic [15:0]          load_seq,
	input  wire logic [15:0]          load_size,
	input  wire logic                 nb_valid,
	input  wire logic [15:0]          nb_seq,
	input  wire logic [15:0]          nb_size,
	output logic                      valid_q,
	output logic [15:0]               seq_q,
	output logic [15:0]               size_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (load_here) begin
			valid_q <= 1'b1;
		end else if (shift) begin
			valid_q <= nb_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_here) begin
			seq_q  <= load_seq;
			size_q <= load_size;
		end else if (shift) begin
			seq_q  <= nb_seq;
			size_q <= nb_size;
		end
	end
endmodule
`default_nettype wire

>>> sv/fbwt_row.sv
// Row of media cells; head at cell 0, oldest first, contiguous valid run
`timescale 1ns / 1ps
`default_nettype none
module fbwt_row (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire fbwt_pkg::row_ctl_t       ctl,
	input  wire logic [fbwt_pkg::HeldW-1:0] held,
	output logic [15:0]                   head_seq,
	output logic [15:0]                   head_size
);
	import fbwt_pkg::*;

	logic [MaxMedia-1:0] v;
	logic [15:0]         sq [MaxMedia];
	logic [15:0]         sz [MaxMedia];
	logic [HeldW-1:0]    tail;

	// on a plain rotate with keep, head goes to slot held-1; with drop, run shrinks
	assign tail = (ctl.shift && held != '0) ? HeldW'(held - HeldW'(1)) : held;

	for (genvar i = 0; i < MaxMedia; i++) begin : g_cell
		logic nv;
		logic [15:0] ns, nz;
		logic ld;
		if (i == MaxMedia - 1) begin : g_last
			assign nv = 1'b0;
			assign ns = sq[i];
			assign nz = sz[i];
		end else begin : g_mid
			assign nv = v[i+1];
			assign ns = sq[i+1];
			assign nz = sz[i+1];
		end
		assign ld = (ctl.load && !ctl.shift && held == HeldW'(i))
			|| (ctl.shift && ctl.keep && tail == HeldW'(i));
		fbwt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (ctl.shift),
			.clear     (ctl.clear),
			.load_here (ld),
			.load_seq  (ctl.shift ? sq[0] : ctl.seq),
			.load_size (ctl.shift ? sz[0] : ctl.size),
			.nb_valid  (nv),
			.nb_seq    (ns),
			.nb_size   (nz),
			.valid_q   (v[i]),
			.seq_q     (sq[i]),
			.size_q    (sz[i])
		);
	end

	assign head_seq  = sq[0];
	assign head_size = sz[0];
endmodule
`default_nettype wire

>>> sv/fbwt_ram.sv
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module fbwt_ram #(
	parameter int Width = 16,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic [Width-1:0]              rdata_q
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata_q <= mem[addr];
	end
endmodule
`default_nettype wire

>>> sv/fec_block_window_tracker_top.sv
// Top level of the FEC block window tracker
// Usage:
//  in  : sink channel, word = opcode, seq_number, block_base, packet_size.
//  out : source channel, one word per input word (action, present_mask,
//        largest_size_out, base_out, repair_held).
//  cfg : media_count write channel, taken only while no word is in work.
// Media words are held in a row of cells that shifts toward cell 0 once a
// cycle during a pass; a full pass over the row rotates the ring so every stored
// word is seen at the head. Repair numbers sit in a small RAM read one per cycle.
// A media word goes through a duplicate pass, drop, store and judge; a repair
// word through a pass over the stored repairs, a scan of the row and judge.
// One word is in work at a time; the next is taken once its result has
// been loaded into the output register, so the result may wait there.
// Reset clears all control state and sets media_count to 8; no clear pass.
// When out stalls the result holds until it is taken; in may take one more word, whose result then waits.
`timescale 1ns / 1ps
`default_nettype none
module fec_block_window_tracker_top (
	input  wire logic clk,
	input  wire logic arst_n,
	fbwt_if.sink      in,
	fbwt_if.source    out,
	fbwt_if.sink      cfg
);
	import fbwt_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_RDUP  = 7'b0000010,
		ST_MDUP  = 7'b0000100,
		ST_DROP  = 7'b0001000,
		ST_SCAN  = 7'b0010000,
		ST_DONE  = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t           state_q;
	in_word_t         w_q;
	logic [5:0]       mcount_q;
	logic [HeldW-1:0] held_q;
	logic [RcntW-1:0] rcnt_q;
	logic [15:0]      base_q, blocked_q, largest_q;
	logic             based_q;
	logic [31:0]      mask_q;
	logic [HeldW-1:0] k_q, kept_q;
	logic [RcntW-1:0] rk_q;
	logic             rvalid_s1, dup_q;
	action_t          act_q;
	out_word_t        res_q;
	logic             res_v_q;

	logic [HeldW-1:0] m;
	logic [31:0]      fmask;
	row_ctl_t         ctl;
	logic [15:0]      hseq, hsize, rdata;
	logic             ram_we;
	logic [RepW-1:0]  ram_addr;
	logic [16:0]      win_dist, hdist;
	logic [HeldW-1:0] row_held;

	assign m        = eff_count(mcount_q);
	assign fmask    = (m >= HeldW'(32)) ? 32'hFFFF_FFFF : ((32'd1 << m) - 32'd1);
	assign win_dist = seq_dist(w_q.seq_number, base_q, m);
	assign hdist    = seq_dist(hseq, base_q, m);

	// while scanning, kept words close up behind the unscanned ones
	assign row_held = (state_q == ST_SCAN) ? HeldW'(held_q - k_q + kept_q) : held_q;

	fbwt_row u_row (.clk(clk), .arst_n(arst_n), .ctl(ctl), .held(row_held),
		.head_seq(hseq), .head_size(hsize));

	fbwt_ram #(.Width(16), .Depth(MaxRepair)) u_rep (.clk(clk), .we(ram_we),
		.addr(ram_addr), .wdata(w_q.seq_number), .rdata_q(rdata));

	assign in.ready  = (state_q == ST_IDLE) && !cfg.valid;
	assign cfg.ready = (state_q == ST_IDLE);
	assign out.valid = res_v_q;
	assign out.data  = res_q;

	// repair RAM: read rk_q during the repair duplicate pass, write at rcnt on store
	always_comb begin
		ram_we   = 1'b0;
		ram_addr = rk_q[RepW-1:0];
		if (state_q == ST_DONE && w_q.opcode && act_q == ACT_STORED) begin
			ram_we   = 1'b1;
			ram_addr = rcnt_q[RepW-1:0];
		end
	end

	// row control
	always_comb begin
		ctl       = '0;
		ctl.seq   = w_q.seq_number;
		ctl.size  = w_q.packet_size;
		unique case (state_q)
			ST_MDUP: begin
				if (k_q < held_q) begin
					ctl.shift = 1'b1;
					ctl.keep  = 1'b1;
				end
			end
			ST_DROP: begin
				if (held_q >= m || held_q >= HeldW'(MaxMedia)) ctl.shift = 1'b1;
				else ctl.load = 1'b1;
			end
			ST_SCAN: begin
				if (k_q < held_q) begin
					ctl.shift = 1'b1;
					ctl.keep  = (hdist < 17'(m));
				end
			end
			ST_DONE: ctl.clear = (act_q == ACT_COMPLETE || act_q == ACT_RECOVER);
			default: ;
		endcase
		if (state_q == ST_IDLE && cfg.valid) ctl.clear = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mcount_q  <= 6'd8;
			held_q    <= '0;
			rcnt_q    <= '0;
			base_q    <= '0;
			blocked_q <= '0;
			largest_q <= '0;
			based_q   <= 1'b0;
			mask_q    <= '0;
			k_q       <= '0;
			kept_q    <= '0;
			rk_q      <= '0;
			rvalid_s1 <= 1'b0;
			dup_q     <= 1'b0;
			act_q     <= ACT_STORED;
			res_v_q   <= 1'b0;
		end else begin
			if (out.valid && out.ready && state_q != ST_EMIT) res_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg.valid) begin
						mcount_q  <= cfg.data;
						blocked_q <= base_q;
						based_q   <= 1'b0;
						mask_q    <= '0;
						held_q    <= '0;
						rcnt_q    <= '0;
						largest_q <= '0;
					end else if (in.valid) begin
						w_q   <= in.data;
						k_q   <= '0;
						rk_q  <= '0;
						dup_q <= 1'b0;
						act_q <= (in.data.opcode && in.data.block_base == blocked_q)
							? ACT_BLACKLIST : ACT_STORED;
						if (in.data.opcode) begin
							if (in.data.block_base == blocked_q) begin
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_RDUP;
							end
						end else begin
							state_q <= ST_MDUP;
						end
					end
				end
				ST_RDUP: begin
					// RAM read of rk_q lands in the next cycle
					if (rvalid_s1 && rdata == w_q.seq_number) dup_q <= 1'b1;
					rvalid_s1 <= (rk_q < rcnt_q);
					if (rk_q < rcnt_q) begin
						rk_q      <= rk_q + RcntW'(1);
					end else if (!rvalid_s1) begin
						if (dup_q) begin
							act_q   <= ACT_DUPLICATE;
							state_q <= ST_DONE;
						end else if ((base_q == w_q.block_base ? rcnt_q : '0)
							>= RcntW'(MaxRepair)) begin
							act_q   <= ACT_REPFULL;
							state_q <= ST_DONE;
						end else begin
							rcnt_q    <= (base_q == w_q.block_base) ? rcnt_q : '0;
							base_q    <= w_q.block_base;
							based_q   <= 1'b1;
							mask_q    <= '0;
							largest_q <= '0;
							kept_q    <= '0;
							state_q   <= ST_SCAN;
						end
					end
				end
				ST_MDUP: begin
					if (k_q < held_q) begin
						if (hseq == w_q.seq_number) dup_q <= 1'b1;
						k_q <= k_q + HeldW'(1);
					end else if (dup_q) begin
						act_q   <= ACT_DUPLICATE;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DROP;
					end
				end
				ST_DROP: begin
					if (held_q >= m || held_q >= HeldW'(MaxMedia)) begin
						held_q <= held_q - HeldW'(1);
					end else begin
						held_q <= held_q + HeldW'(1);
						if (!based_q) begin
							act_q <= ACT_STORED;
						end else if (win_dist >= 17'(m)) begin
							based_q   <= 1'b0;
							blocked_q <= base_q;
							rcnt_q    <= '0;
							act_q     <= ACT_WINRESET;
						end else begin
							mask_q <= mask_q | (32'd1 << win_dist[4:0]);
							if (w_q.packet_size > largest_q) largest_q <= w_q.packet_size;
						end
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (k_q < held_q) begin
						k_q <= k_q + HeldW'(1);
						if (hdist < 17'(m)) begin
							kept_q <= kept_q + HeldW'(1);
							mask_q <= mask_q | (32'd1 << hdist[4:0]);
							if (hsize > largest_q) largest_q <= hsize;
						end
					end else begin
						held_q  <= kept_q;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (act_q == ACT_STORED) begin
						if (w_q.opcode) rcnt_q <= rcnt_q + RcntW'(1);
						if ((based_q || w_q.opcode) && !(act_q != ACT_STORED)) begin
							if ((mask_q == fmask)
								|| (held_q != '0 && (7'(held_q) + 7'(rcnt_q)
								+ 7'(w_q.opcode)) >= 7'(m))) begin
								act_q     <= (mask_q == fmask) ? ACT_COMPLETE : ACT_RECOVER;
								blocked_q <= base_q;
								based_q   <= 1'b0;
							end
						end
						state_q <= (based_q && ((mask_q == fmask) || (held_q != '0
							&& (7'(held_q) + 7'(rcnt_q) + 7'(w_q.opcode)) >= 7'(m))))
							? ST_DONE : ST_EMIT;
					end else begin
						if (act_q == ACT_COMPLETE || act_q == ACT_RECOVER) begin
							mask_q    <= '0;
							held_q    <= '0;
							rcnt_q    <= '0;
							largest_q <= '0;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!res_v_q || out.ready) begin
						res_v_q                  <= 1'b1;
						res_q.action             <= act_q;
						res_q.present_mask       <= mask_q;
						res_q.largest_size_out   <= largest_q;
						res_q.base_out           <= base_q;
						res_q.repair_held        <= 5'(rcnt_q);
						state_q                  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/fbwt_checker.sv
// Port-level checker for the block window tracker, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "fec_block_window_tracker_top_assert.svh"
module fbwt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  out_action,
	input wire logic        cfg_ready
);
	import fbwt_pkg::*;
	`FBWT_ASSERT_NXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)
	`FBWT_ASSERT_IMP(a_no_ignored, clk, arst_n, out_valid, out_action != ACT_IGNORED)
	`FBWT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`FBWT_ASSERT_IMP(a_cfg_idle, clk, arst_n, in_ready, cfg_ready)
endmodule

bind fec_block_window_tracker_top fbwt_checker u_fbwt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in.valid),
	.in_ready   (in.ready),
	.out_valid  (out.valid),
	.out_ready  (out.ready),
	.out_action (out.data.action),
	.cfg_ready  (cfg.ready)
);
`default_nettype wire

>>> bench/fbwt_result_checker.sv
// Checker: predicts the block window tracker and compares every result word
`timescale 1ns / 1ps
`default_nettype none
module fbwt_result_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_ready,
	input  fbwt_pkg::in_word_t  in_data,
	input  wire logic          out_valid,
	input  wire logic          out_ready,
	input  fbwt_pkg::out_word_t out_data,
	input  wire logic          cfg_valid,
	input  wire logic          cfg_ready,
	input  wire logic [5:0]    cfg_data,
	output int                 errors,
	output int                 pending,
	output int                 results_seen,
	output int                 recoveries
);
	import fbwt_pkg::*;

	logic [15:0] media_seq_q[$];
	logic [15:0] media_size_q[$];
	logic [15:0] repair_seq_q[$];
	int unsigned win_base;
	int unsigned barred_base;
	bit          base_valid;
	logic [31:0] seen_mask;
	int unsigned max_size;
	logic [5:0]  media_cfg;
	out_word_t   expected_q[$];

	function automatic int unsigned block_len();
		int unsigned m;
		m = media_cfg;
		if (m == 0) m = 1;
		if (m > MaxMedia) m = MaxMedia;
		return m;
	endfunction

	function automatic int unsigned unwrap(input logic [15:0] s);
		int unsigned v;
		v = s;
		if (win_base + block_len() > 65536 && v < win_base) v += 65536;
		return v;
	endfunction

	function automatic logic [31:0] all_present();
		return (block_len() >= 32) ? 32'hFFFF_FFFF : ((32'd1 << block_len()) - 1);
	endfunction

	function automatic void clear_block();
		barred_base = win_base;
		base_valid = 0;
		seen_mask = '0;
		media_seq_q.delete();
		media_size_q.delete();
		repair_seq_q.delete();
		max_size = 0;
	endfunction

	function automatic void keep_media(input logic [15:0] s, input logic [15:0] sz);
		while (media_seq_q.size() >= block_len()) begin
			void'(media_seq_q.pop_front());
			void'(media_size_q.pop_front());
		end
		media_seq_q.push_back(s);
		media_size_q.push_back(sz);
	endfunction

	function automatic action_t settle_block();
		if (seen_mask == all_present()) begin
			clear_block();
			return ACT_COMPLETE;
		end
		if (media_seq_q.size() > 0 &&
			media_seq_q.size() + repair_seq_q.size() >= block_len()) begin
			clear_block();
			return ACT_RECOVER;
		end
		return ACT_STORED;
	endfunction

	function automatic action_t media_arrival(input logic [15:0] s, input logic [15:0] sz);
		int unsigned d;
		foreach (media_seq_q[k]) if (media_seq_q[k] == s) return ACT_DUPLICATE;
		if (!base_valid) begin
			keep_media(s, sz);
			return ACT_STORED;
		end
		d = unwrap(s) - win_base;
		if (d >= block_len()) begin
			base_valid = 0;
			barred_base = win_base;
			repair_seq_q.delete();
			keep_media(s, sz);
			return ACT_WINRESET;
		end
		keep_media(s, sz);
		seen_mask |= 32'd1 << d[4:0];
		if (sz > max_size) max_size = sz;
		return settle_block();
	endfunction

	function automatic action_t repair_arrival(input logic [15:0] s, input logic [15:0] b);
		logic [15:0] kept_seq[$];
		logic [15:0] kept_size[$];
		int unsigned c;
		int unsigned m;
		m = block_len();
		if (b == barred_base) return ACT_BLACKLIST;
		foreach (repair_seq_q[k]) if (repair_seq_q[k] == s) return ACT_DUPLICATE;
		if (win_base != b) repair_seq_q.delete();
		if (repair_seq_q.size() >= MaxRepair) return ACT_REPFULL;
		win_base = b;
		base_valid = 1;
		seen_mask = '0;
		max_size = 0;
		repair_seq_q.push_back(s);
		foreach (media_seq_q[k]) begin
			c = unwrap(media_seq_q[k]);
			if (c >= b && c <= b + m - 1) begin
				if (media_size_q[k] > max_size) max_size = media_size_q[k];
				seen_mask |= 32'd1 << ((c - b) & 31);
				kept_seq.push_back(media_seq_q[k]);
				kept_size.push_back(media_size_q[k]);
			end
		end
		media_seq_q = kept_seq;
		media_size_q = kept_size;
		return settle_block();
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		results_seen = 0;
		recoveries = 0;
		media_cfg = 6'd8;
		win_base = 0;
		clear_block();
		barred_base = 0;
	end

	always @(posedge clk) begin
		out_word_t w;
		out_word_t e;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				media_cfg = cfg_data;
				clear_block();
			end
			if (in_valid && in_ready) begin
				w.action = in_data.opcode ?
					repair_arrival(in_data.seq_number, in_data.block_base) :
					media_arrival(in_data.seq_number, in_data.packet_size);
				w.present_mask = seen_mask;
				w.largest_size_out = max_size[15:0];
				w.base_out = win_base[15:0];
				w.repair_held = 5'(repair_seq_q.size());
				expected_q.push_back(w);
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					report("unexpected word", 32'(out_data.action), 32'd0);
				end else begin
					e = expected_q.pop_front();
					if (e.action == ACT_RECOVER || e.action == ACT_COMPLETE) recoveries++;
					if (out_data.action != e.action) report("action", out_data.action, e.action);
					if (out_data.present_mask != e.present_mask)
						report("present_mask", out_data.present_mask, e.present_mask);
					if (out_data.largest_size_out != e.largest_size_out)
						report("largest_size", out_data.largest_size_out, e.largest_size_out);
					if (out_data.base_out != e.base_out)
						report("base_out", out_data.base_out, e.base_out);
					if (out_data.repair_held != e.repair_held)
						report("repair_held", out_data.repair_held, e.repair_held);
				end
			end
			pending = expected_q.size();
		end
	end
endmodule
`default_nettype wire

>>> bench/tb_fec_block_window_tracker_top.sv
// Testbench top: stimulus, idling, configuration phases and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_fec_block_window_tracker_top;
	import fbwt_pkg::*;

	localparam int CycleLimit = 600000;

	logic clk;
	logic arst_n;
	int   errors, pending, results_seen, recoveries;
	int   cycles;
	int   items_sent;
	int   cfg_writes;
	bit   quiet;
	bit   hold_req;
	logic [5:0] cur_cfg;

	fbwt_if #(.T(in_word_t))   in_ch ();
	fbwt_if #(.T(out_word_t))  out_ch ();
	fbwt_if #(.T(logic [5:0])) cfg_ch ();

	fec_block_window_tracker_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch),
		.out    (out_ch),
		.cfg    (cfg_ch)
	);

	fbwt_result_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.in_data      (in_ch.data),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.out_data     (out_ch.data),
		.cfg_valid    (cfg_ch.valid),
		.cfg_ready    (cfg_ch.ready),
		.cfg_data     (cfg_ch.data),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen),
		.recoveries   (recoveries)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		out_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_ch.ready <= 0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_ch.ready <= 1;
			end
		end
	end

	function automatic int unsigned block_len();
		int unsigned m;
		m = cur_cfg;
		if (m == 0) m = 1;
		if (m > MaxMedia) m = MaxMedia;
		return m;
	endfunction

	task automatic send_word(input logic op, input logic [15:0] s, input logic [15:0] b,
		input logic [15:0] sz);
		in_ch.valid <= 1;
		in_ch.data <= '{opcode: op, seq_number: s, block_base: b, packet_size: sz};
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_media_count(input logic [5:0] v);
		wait_drained();
		cfg_ch.valid <= 1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 0;
		cur_cfg = v;
		cfg_writes++;
	endtask

	// one protected block: repairs of one base, media of its window, some noise
	task automatic block_burst(input int n);
		logic [15:0] b;
		int unsigned m;
		int k;
		m = block_len();
		case ($urandom_range(0, 3))
			0: b = 16'($urandom_range(65536 - 40, 65535));
			1: b = 16'($urandom_range(0, 40));
			default: b = 16'($urandom);
		endcase
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 9))
				0, 1: send_word(1, 16'($urandom_range(0, 20)), b, 16'($urandom));
				2: send_word(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
					16'($urandom));
				3: send_word(0, b + 16'($urandom_range(0, m + 3)), 16'($urandom), 16'($urandom));
				default: send_word(0, b + 16'($urandom_range(0, m - 1)), 16'($urandom),
					16'($urandom));
			endcase
		end
	endtask

	initial begin
		logic [5:0] cfg_plan[8];
		int k, p;
		cfg_plan = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd5, 6'd8, 6'd17, 6'd3};
		items_sent = 0;
		cfg_writes = 0;
		quiet = 0;
		hold_req = 0;
		cur_cfg = 6'd8;
		in_ch.valid = 0;
		in_ch.data = '0;
		cfg_ch.valid = 0;
		cfg_ch.data = '0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed
		send_word(0, 16'd0, 16'hFFFF, 16'd0);
		send_word(0, 16'd0, 16'd0, 16'd7);
		send_word(0, 16'hFFFF, 16'd0, 16'hFFFF);
		send_word(1, 16'd1, 16'd0, 16'd0);
		send_word(1, 16'd2, 16'hFFFC, 16'hFFFF);
		send_word(1, 16'd2, 16'hFFFC, 16'd0);
		send_word(0, 16'hFFFD, 16'd0, 16'd12);
		send_word(0, 16'hFFFC, 16'd0, 16'd99);
		send_word(1, 16'd3, 16'd100, 16'd0);
		send_word(0, 16'd5000, 16'd0, 16'd1);
		send_word(1, 16'd4, 16'd100, 16'd0);
		write_media_count(6'd32);
		for (k = 0; k < 17; k++) send_word(1, 16'(300 + k), 16'd200, 16'($urandom));
		write_media_count(6'd0);
		send_word(1, 16'd9, 16'd40, 16'd0);
		send_word(0, 16'd40, 16'd0, 16'd500);

		// random phases
		for (p = 0; p < 8; p++) begin
			write_media_count((p == 6) ? 6'($urandom) : cfg_plan[p]);
			if (p == 3) begin
				hold_req = 1;
				for (k = 0; k < 30; k++)
					send_word(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
						16'($urandom));
			end
			if (p == 7) quiet = 1;
			k = 0;
			while (k < 70) begin
				block_burst(block_len() + 4);
				k += block_len() + 4;
			end
		end

		wait_drained();
		$display("sent %0d words over %0d media_count settings, %0d results checked",
			items_sent, cfg_writes, results_seen);
		$display("%0d blocks ended complete or ready for recovery", recoveries);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
